[rtl/iso8211_directory_parser_top_macros.svh]
// assertion macros for the iso 8211 directory parser
`ifndef ISO8211_DIRECTORY_PARSER_TOP_MACROS_SVH
`define ISO8211_DIRECTORY_PARSER_TOP_MACROS_SVH

// implication checked on every clock edge outside reset
`define IDP_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("idp check failed");

// implication whose right side is checked in the following cycle
`define IDP_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("idp check failed");

`endif

[rtl/idp_pkg.sv]
`default_nettype none
package idp_pkg;
   localparam int MAX_TAGS_DEF  = 64;
   localparam int TAG_BYTES_DEF = 4;
   localparam logic [16:0] LEADER_SIZE = 17'd24;
   localparam logic [7:0] FIELD_TERM = 8'h1E;
   localparam logic [17:0] NUM_CAP = 18'h3FFFF;

   localparam logic [1:0] PH_LEADER = 2'd0;
   localparam logic [1:0] PH_DIR    = 2'd1;
   localparam logic [1:0] PH_SKIP   = 2'd2;
   localparam logic [1:0] PH_HALT   = 2'd3;

   localparam logic [1:0] KIND_ENTRY = 2'd0;
   localparam logic [1:0] KIND_REND  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;
   localparam logic [1:0] KIND_EOD   = 2'd3;

   localparam logic [3:0] ERR_NONE          = 4'd0;
   localparam logic [3:0] ERR_BAD_DDR       = 4'd1;
   localparam logic [3:0] ERR_DDR_LEADER    = 4'd2;
   localparam logic [3:0] ERR_DDR_OUTSIDE   = 4'd3;
   localparam logic [3:0] ERR_LARGE_RECORD  = 4'd4;
   localparam logic [3:0] ERR_REUSE_HEADER  = 4'd5;
   localparam logic [3:0] ERR_CORRUPT       = 4'd6;
   localparam logic [3:0] ERR_FIELD_OUTSIDE = 4'd7;
   localparam logic [3:0] ERR_TABLE_FULL    = 4'd8;
   localparam logic [3:0] ERR_TAG_WIDE      = 4'd9;
   localparam logic [3:0] ERR_TRUNCATED     = 4'd10;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] entry_tag;
      logic [16:0] entry_length;
      logic [16:0] entry_position;
      logic [5:0]  tag_slot;
      logic        from_descriptive;
      logic [3:0]  error_code;
      logic        last;
   } rsp_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   // one atoi step; flags bit0 digits started, bit1 stopped
   function automatic logic [19:0] scan_step(input logic [17:0] acc, input logic [1:0] fl,
                                             input logic [7:0] b);
      logic [21:0] v;
      logic [17:0] a;
      logic [1:0]  f;
      a = acc;
      f = fl;
      v = {acc, 3'b000} + {2'b00, acc, 1'b0} + {14'd0, b - 8'h30};
      if (fl[1]) begin
         a = acc;
      end else if (!fl[0] && is_space(b)) begin
         a = acc;
      end else if (is_digit(b)) begin
         a = (v > {4'd0, NUM_CAP}) ? NUM_CAP : v[17:0];
         f[0] = 1'b1;
      end else begin
         f[1] = 1'b1;
      end
      return {f, a};
   endfunction
endpackage
`default_nettype wire

[rtl/iso8211_directory_parser_top.sv]
// iso 8211 record directory parser, one stream byte per item
// the first result of a byte is loaded into the output register when the byte is accepted
// throughput: one byte per cycle while rsp_ready keeps the output draining; a byte that causes two
// results holds the input while its second result waits in the skid register
// reset: synchronous active high; expects a descriptive leader, tag table count cleared
`default_nettype none
module iso8211_directory_parser_top #(
   parameter int MAX_TAGS  = idp_pkg::MAX_TAGS_DEF,
   parameter int TAG_BYTES = idp_pkg::TAG_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic        req_stream_start,
   input  wire logic        req_stream_end,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [31:0]      rsp_entry_tag,
   output logic [16:0]      rsp_entry_length,
   output logic [16:0]      rsp_entry_position,
   output logic [5:0]       rsp_tag_slot,
   output logic             rsp_from_descriptive,
   output logic [3:0]       rsp_error_code,
   output logic             rsp_last
);
   import idp_pkg::*;

   localparam int SW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
   localparam int CW = $clog2(MAX_TAGS + 1);

   // parser state
   logic [1:0]  phase_ff, phase_in;
   logic [16:0] bir_ff, bir_in;
   logic [16:0] rlen_ff, rlen_in;
   logic [16:0] fas_ff, fas_in;
   logic [3:0]  sol_ff, sol_in, sop_ff, sop_in, sot_ff, sot_in;
   logic [6:0]  ctl_ff, ctl_in;
   logic [4:0]  eb_ff, eb_in;
   logic [63:0] tag_ff, tag_in;
   logic [17:0] num_ff, num_in;
   logic [16:0] slen_ff, slen_in;
   logic [1:0]  fl_ff, fl_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic        desc_ff, desc_in;
   logic [7:0]  lid_ff, lid_in;

   // tag table held in registers, compared in parallel
   logic [63:0] tbl_ff [MAX_TAGS];
   logic [3:0]  tsz_ff [MAX_TAGS];
   logic        tbl_we;

   // output register and second-result skid
   rsp_type out_ff, out_in;
   logic    ov_ff, ov_in;
   rsp_type sec_ff, sec_in;
   logic    sv_ff, sv_in;

   logic accept;
   rsp_type r0, r1;
   logic    n0, n1;

   logic [7:0]  b;
   logic        st, en;
   logic [19:0] sc;
   logic [1:0]  ph;
   logic        desc;
   logic [16:0] bir;
   logic [5:0]  ew;
   logic [63:0] low;
   logic [SW-1:0] hit_slot;
   logic        hit;
   logic [18:0] bound;
   logic [3:0]  err;
   logic [16:0] rl;
   logic [17:0] ns;

   // space frees when the registers drain
   assign req_ready = !sv_ff && (!ov_ff || rsp_ready);
   assign accept = req_valid && req_ready;

   always_comb begin
      low = '0;
      for (int i = 0; i < 8; i++) begin
         if (i < 32'(sot_ff)) begin
            low[8*i +: 8] = (tag_in[8*i +: 8] >= 8'h41 && tag_in[8*i +: 8] <= 8'h5A)
                            ? tag_in[8*i +: 8] + 8'h20 : tag_in[8*i +: 8];
         end
      end
   end

   always_comb begin
      hit = 1'b0;
      hit_slot = '0;
      for (int i = MAX_TAGS - 1; i >= 0; i--) begin
         if (i < 32'(cnt_ff) && tsz_ff[i] == sot_ff && tbl_ff[i] == low) begin
            hit = 1'b1;
            hit_slot = SW'(i);
         end
      end
   end

   function automatic rsp_type mk(input logic [1:0] k, input logic [3:0] c, input logic d);
      rsp_type r;
      r = '0;
      r.kind = k;
      r.error_code = c;
      r.from_descriptive = d;
      return r;
   endfunction

   always_comb begin
      b  = req_byte_value;
      st = req_stream_start;
      en = req_stream_end;
      phase_in = phase_ff; bir_in = bir_ff; rlen_in = rlen_ff; fas_in = fas_ff;
      sol_in = sol_ff; sop_in = sop_ff; sot_in = sot_ff; ctl_in = ctl_ff;
      eb_in = eb_ff; tag_in = tag_ff; num_in = num_ff; slen_in = slen_ff;
      fl_in = fl_ff; cnt_in = cnt_ff; desc_in = desc_ff; lid_in = lid_ff;
      tbl_we = 1'b0;
      r0 = '0; r1 = '0; n0 = 1'b0; n1 = 1'b0;
      err = ERR_NONE;
      sc = '0; rl = '0; ns = '0; bound = '0;
      ew = 6'(sot_ff) + 6'(sol_ff) + 6'(sop_ff);
      if (st) begin
         phase_in = PH_LEADER; bir_in = '0; rlen_in = '0; fas_in = '0;
         sol_in = '0; sop_in = '0; sot_in = '0; ctl_in = '0; eb_in = '0;
         tag_in = '0; num_in = '0; slen_in = '0; fl_in = '0; cnt_in = '0;
         desc_in = 1'b1; lid_in = '0;
         ew = '0;
      end
      ph = phase_in; desc = desc_in; bir = bir_in;
      if (ph == PH_HALT) begin
         // no result
      end else if (ph == PH_LEADER) begin
         if (!desc && bir == 17'd0 && (b == 8'h5E || b == 8'h00)) begin
            phase_in = PH_HALT; n0 = 1'b1; r0 = mk(KIND_EOD, ERR_NONE, desc);
         end else begin
            if (bir == 17'd0 || bir == 17'd10 || bir == 17'd12 || bir >= 17'd20)
               sc = scan_step(18'd0, 2'b00, b);
            else
               sc = scan_step(num_in, fl_in, b);
            if (bir <= 17'd4 || bir == 17'd10 || bir == 17'd11 ||
                (bir >= 17'd12 && bir <= 17'd16) || bir == 17'd20 ||
                bir == 17'd21 || bir == 17'd23) begin
               num_in = sc[17:0]; fl_in = sc[19:18];
            end
            rl = rlen_in;
            if (bir == 17'd4) begin rlen_in = sc[16:0]; rl = sc[16:0]; end
            if (bir == 17'd6) lid_in = b;
            if (bir == 17'd11) ctl_in = sc[6:0];
            if (bir == 17'd16) fas_in = sc[16:0];
            if (bir == 17'd20) sol_in = sc[3:0];
            if (bir == 17'd21) sop_in = sc[3:0];
            if (bir == 17'd23) sot_in = sc[3:0];
            if (bir < LEADER_SIZE - 17'd1) begin
               if (en) begin
                  phase_in = PH_HALT; n0 = 1'b1;
                  r0 = desc ? mk(KIND_ERROR, ERR_TRUNCATED, desc) : mk(KIND_EOD, ERR_NONE, desc);
               end else begin
                  bir_in = bir + 17'd1;
               end
            end else begin
               // sizes are single digits, so sc[3:0] holds them fully
               if (desc) begin
                  if (rl < LEADER_SIZE || lid_in != 8'h4C) err = ERR_BAD_DDR;
                  else if (ctl_in == 7'd0 || fas_in < LEADER_SIZE || fas_in >= rl ||
                           sol_in == 4'd0 || sop_in == 4'd0 || sot_in == 4'd0)
                     err = ERR_DDR_LEADER;
                  else if (32'(sot_in) > TAG_BYTES) err = ERR_TAG_WIDE;
                  else if (en) err = ERR_TRUNCATED;
               end else begin
                  if (rl == 17'd0) err = ERR_LARGE_RECORD;
                  else if (rl <= LEADER_SIZE) begin
                     phase_in = PH_HALT; n0 = 1'b1; r0 = mk(KIND_EOD, ERR_NONE, desc);
                  end
                  else if (en) err = ERR_TRUNCATED;
                  else if (lid_in == 8'h52) err = ERR_REUSE_HEADER;
                  else if (sol_in == 4'd0 || sop_in == 4'd0 || sot_in == 4'd0 ||
                           fas_in < LEADER_SIZE || fas_in > rl) err = ERR_CORRUPT;
                  else if (32'(sot_in) > TAG_BYTES) err = ERR_TAG_WIDE;
               end
               if (err != ERR_NONE) begin
                  phase_in = PH_HALT; n0 = 1'b1; r0 = mk(KIND_ERROR, err, desc);
               end else if (!n0) begin
                  phase_in = PH_DIR; bir_in = LEADER_SIZE; eb_in = '0;
               end
            end
         end
      end else begin
         if (ph == PH_DIR) begin
            if (eb_in == 5'd0 && (b == FIELD_TERM ||
                                  18'(bir) + 18'(ew) > 18'(rlen_in))) begin
               phase_in = PH_SKIP;
            end else begin
               if (eb_in < 5'(sot_in)) begin
                  tag_in = (eb_in == 5'd0) ? {56'd0, b} : {tag_in[55:0], b};
               end else begin
                  if (eb_in == 5'(sot_in) || eb_in == 5'(sot_in) + 5'(sol_in))
                     sc = scan_step(18'd0, 2'b00, b);
                  else
                     sc = scan_step(num_in, fl_in, b);
                  num_in = sc[17:0]; fl_in = sc[19:18];
                  if (eb_in == 5'(sot_in) + 5'(sol_in) - 5'd1) slen_in = sc[16:0];
               end
               if (6'(eb_in) + 6'd1 >= ew) begin
                  eb_in = '0;
                  ns = num_in;
                  bound = 19'(fas_in) + 19'(ns) + 19'(slen_in);
                  if (bound > 19'(rlen_in)) begin
                     phase_in = PH_HALT; n0 = 1'b1;
                     r0 = mk(KIND_ERROR, desc ? ERR_DDR_OUTSIDE : ERR_FIELD_OUTSIDE, desc);
                  end else if (desc) begin
                     if (32'(cnt_in) >= MAX_TAGS) begin
                        phase_in = PH_HALT; n0 = 1'b1;
                        r0 = mk(KIND_ERROR, ERR_TABLE_FULL, desc);
                     end else begin
                        tbl_we = 1'b1;
                        cnt_in = cnt_in + CW'(1);
                        n0 = 1'b1;
                        r0 = mk(KIND_ENTRY, ERR_NONE, desc);
                        r0.entry_tag = tag_in[31:0];
                        r0.entry_length = slen_in;
                        r0.entry_position = ns[16:0];
                        r0.tag_slot = 6'(cnt_ff);
                     end
                  end else if (hit) begin
                     n0 = 1'b1;
                     r0 = mk(KIND_ENTRY, ERR_NONE, desc);
                     r0.entry_tag = tag_in[31:0];
                     r0.entry_length = slen_in;
                     r0.entry_position = ns[16:0];
                     r0.tag_slot = 6'(hit_slot);
                  end
               end else begin
                  eb_in = eb_in + 5'd1;
               end
            end
         end
         if (phase_in != PH_HALT) begin
            if (bir + 17'd1 == rlen_in) begin
               n1 = 1'b1;
               r1 = mk(en ? KIND_EOD : KIND_REND, ERR_NONE, desc);
               phase_in = en ? PH_HALT : PH_LEADER;
               desc_in = 1'b0;
               bir_in = '0;
            end else if (en) begin
               n1 = 1'b1;
               r1 = mk(KIND_ERROR, ERR_TRUNCATED, desc);
               phase_in = PH_HALT;
            end else begin
               bir_in = bir + 17'd1;
            end
         end
      end
      // the later result carries the last mark
      if (n1) r1.last = 1'b1;
      else if (n0) r0.last = 1'b1;
   end

   // output register and skid stage for the second result of a byte
   always_comb begin
      out_in = out_ff; ov_in = ov_ff; sec_in = sec_ff; sv_in = sv_ff;
      if (ov_ff && rsp_ready) begin
         ov_in = sv_ff; out_in = sec_ff; sv_in = 1'b0;
      end
      if (accept) begin
         if (n0 && n1) begin
            ov_in = 1'b1; out_in = r0; sv_in = 1'b1; sec_in = r1;
         end else if (n0 || n1) begin
            ov_in = 1'b1; out_in = n0 ? r0 : r1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEADER; bir_ff <= '0; rlen_ff <= '0; fas_ff <= '0;
         sol_ff <= '0; sop_ff <= '0; sot_ff <= '0; ctl_ff <= '0; eb_ff <= '0;
         tag_ff <= '0; num_ff <= '0; slen_ff <= '0; fl_ff <= '0; cnt_ff <= '0;
         desc_ff <= 1'b1; lid_ff <= '0; ov_ff <= 1'b0; sv_ff <= 1'b0;
      end else begin
         ov_ff <= ov_in; sv_ff <= sv_in;
         if (accept) begin
            phase_ff <= phase_in; bir_ff <= bir_in; rlen_ff <= rlen_in; fas_ff <= fas_in;
            sol_ff <= sol_in; sop_ff <= sop_in; sot_ff <= sot_in; ctl_ff <= ctl_in;
            eb_ff <= eb_in; tag_ff <= tag_in; num_ff <= num_in; slen_ff <= slen_in;
            fl_ff <= fl_in; cnt_ff <= cnt_in; desc_ff <= desc_in; lid_ff <= lid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      sec_ff <= sec_in;
      if (accept && tbl_we) begin
         tbl_ff[cnt_ff[SW-1:0]] <= low;
         tsz_ff[cnt_ff[SW-1:0]] <= sot_in;
      end
   end

   assign rsp_valid            = ov_ff;
   assign rsp_kind             = out_ff.kind;
   assign rsp_entry_tag        = out_ff.entry_tag;
   assign rsp_entry_length     = out_ff.entry_length;
   assign rsp_entry_position   = out_ff.entry_position;
   assign rsp_tag_slot         = out_ff.tag_slot;
   assign rsp_from_descriptive = out_ff.from_descriptive;
   assign rsp_error_code       = out_ff.error_code;
   assign rsp_last             = out_ff.last;
endmodule
`default_nettype wire

[rtl/idp_checker.sv]
`default_nettype none
`include "iso8211_directory_parser_top_macros.svh"
module idp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_kind,
   input wire logic [3:0] rsp_error_code,
   input wire logic [31:0] rsp_entry_tag
);
   import idp_pkg::*;

   `IDP_ASSERT_IMP(a_err_code, clock, reset, rsp_valid && rsp_kind != KIND_ERROR, rsp_error_code == ERR_NONE)
   `IDP_ASSERT_IMP(a_err_nonzero, clock, reset, rsp_valid && rsp_kind == KIND_ERROR, rsp_error_code != ERR_NONE)
   `IDP_ASSERT_IMP(a_tag_zero, clock, reset, rsp_valid && rsp_kind != KIND_ENTRY, rsp_entry_tag == 32'd0)
   `IDP_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind))
endmodule

bind iso8211_directory_parser_top idp_checker u_idp_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
   .rsp_error_code(rsp_error_code), .rsp_entry_tag(rsp_entry_tag)
);
`default_nettype wire
